>>> src/msmr_pkg.sv
// shared types, constants and scale tables for the midi scale mode remapper
// no dependencies; imported by every module of the block

package msmr_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int NOTE_W     = 7;

  // stored per-note entry codes
  localparam logic [7:0] MAP_DROP = 8'd128;
  localparam logic [7:0] MAP_NONE = 8'd129;

  // midi command nibbles
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_OFFSET = 2'd0;
  localparam logic [1:0] CFG_TO_MINOR   = 2'd1;
  localparam logic [1:0] CFG_QUIRK_MODE = 2'd2;

  // retry shift codes for an unmapped pitch class
  localparam logic [1:0] QUIRK_BELOW = 2'd0;
  localparam logic [1:0] QUIRK_SKIP  = 2'd1;
  localparam logic [1:0] QUIRK_ABOVE = 2'd2;

  // scale table entry: hit flag and target class 0..12
  typedef struct packed {
    logic       hit;
    logic [3:0] cls;
  } tab_entry_t;

  // write command into the per-note store
  typedef struct packed {
    logic              set;
    logic              clr;
    logic [NOTE_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // 13-entry scale tables, minor selected by to_minor
  function automatic tab_entry_t tab_lookup(input logic to_minor, input logic [3:0] idx);
    tab_entry_t e;
    e.hit = 1'b1;
    e.cls = 4'd0;
    if (to_minor) begin
      case (idx)
        4'd0:  e.cls = 4'd0;
        4'd1:  e.cls = 4'd1;
        4'd2:  e.cls = 4'd2;
        4'd4:  e.cls = 4'd3;
        4'd5:  e.cls = 4'd5;
        4'd6:  e.cls = 4'd6;
        4'd7:  e.cls = 4'd7;
        4'd9:  e.cls = 4'd8;
        4'd10: e.cls = 4'd9;
        4'd11: e.cls = 4'd10;
        4'd12: e.cls = 4'd12;
        default: e.hit = 1'b0;
      endcase
    end else begin
      case (idx)
        4'd0:  e.cls = 4'd0;
        4'd1:  e.cls = 4'd1;
        4'd2:  e.cls = 4'd2;
        4'd3:  e.cls = 4'd4;
        4'd5:  e.cls = 4'd5;
        4'd6:  e.cls = 4'd6;
        4'd7:  e.cls = 4'd7;
        4'd8:  e.cls = 4'd9;
        4'd9:  e.cls = 4'd10;
        4'd10: e.cls = 4'd11;
        4'd12: e.cls = 4'd12;
        default: e.hit = 1'b0;
      endcase
    end
    return e;
  endfunction

endpackage

>>> src/msmr_remap.sv
// note remap datapath: key offset, octave split, table lookup with retry
// depends on msmr_pkg

module msmr_remap
  import msmr_pkg::*;
(
  input  logic [NOTE_W-1:0] note,
  input  logic [3:0]        key_offset,
  input  logic              to_minor,
  input  logic [1:0]        quirk_mode,
  output logic [7:0]        result
);

  logic [3:0]  off;
  logic [7:0]  adj;
  logic [15:0] prod;
  logic [3:0]  oct;
  logic [7:0]  oct12;
  logic [3:0]  cls;
  logic        retry_ok;
  logic [3:0]  retry_idx;
  tab_entry_t  first;
  tab_entry_t  second;
  logic        hit;
  logic [3:0]  tgt;
  logic [8:0]  res;

  // offset reduced into 0..11
  assign off = (key_offset >= 4'd12) ? (key_offset - 4'd12) : key_offset;
  assign adj = {1'b0, note} + {4'b0, off};

  // divide by twelve through reciprocal multiply, exact for adj up to 138
  assign prod  = {8'b0, adj} * 16'd171;
  assign oct   = prod[14:11];
  assign oct12 = {4'b0, oct} * 8'd12;
  assign cls   = 4'(adj - oct12);

  // retry index after the quirk shift
  always_comb begin
    retry_ok  = 1'b1;
    retry_idx = cls;
    case (quirk_mode)
      QUIRK_BELOW: begin
        if (cls == 4'd0) begin
          retry_ok = 1'b0;
        end else begin
          retry_idx = cls - 4'd1;
        end
      end
      QUIRK_ABOVE: retry_idx = cls + 4'd1;
      default:     retry_idx = cls;
    endcase
  end

  assign first  = tab_lookup(to_minor, cls);
  assign second = tab_lookup(to_minor, retry_idx);
  assign hit    = first.hit || (retry_ok && second.hit);
  assign tgt    = first.hit ? first.cls : second.cls;

  // new note is note - cls + target class
  assign res = {2'b0, note} + {5'b0, tgt} - {5'b0, cls};

  always_comb begin
    if (!hit || res[8] || res[7]) begin
      result = MAP_DROP;
    end else begin
      result = {1'b0, res[6:0]};
    end
  end

endmodule

>>> src/msmr_note_store.sv
// per-note mapping store: entry memory with registered read, valid flops, bypass
// depends on msmr_pkg

module msmr_note_store
  import msmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [NOTE_W-1:0] rd_addr,
  input  logic [NOTE_W-1:0] lk_addr,
  input  store_wr_t         wr,
  output logic [7:0]        entry
);

  logic [7:0]            mem [NOTE_COUNT];
  logic [NOTE_COUNT-1:0] filled;
  logic [7:0]            rd_data;
  logic                  byp_hit;
  logic [7:0]            byp_data;

  // entry memory, one write and one read port
  always_ff @(posedge clk) begin
    if (wr.set) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data  <= mem[rd_addr];
      byp_hit  <= wr.set && (wr.addr == rd_addr);
      byp_data <= wr.data;
    end
  end

  // valid bits, cleared together on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr.set) begin
      filled[wr.addr] <= 1'b1;
    end else if (wr.clr) begin
      filled[wr.addr] <= 1'b0;
    end
  end

  // unfilled entries read as not mapped
  assign entry = filled[lk_addr] ? (byp_hit ? byp_data : rd_data) : MAP_NONE;

endmodule

>>> src/midi_scale_mode_remapper.sv
// Remaps MIDI note-on/note-off messages between major and minor modes and passes other
// messages through. One item is accepted per clock unless the output stalls; it passes
// the working stage register, then the output register. The note memory is read at the
// accept edge and written when the item leaves the working stage, with a bypass for a
// same-note write in that edge, which sets the one-item-per-cycle figure. Unmappable
// rolling note-ons produce no result. Configuration writes are always accepted.
// top level; depends on msmr_pkg, msmr_remap, msmr_note_store

module midi_scale_mode_remapper
  import msmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        status_byte,
  input  logic [NOTE_W-1:0] data_one,
  input  logic [6:0]        data_two,
  input  logic [1:0]        msg_length,
  input  logic [15:0]       frame_time,
  input  logic              rolling,
  // output channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_status,
  output logic [NOTE_W-1:0] out_data_one,
  output logic [6:0]        out_data_two,
  output logic [1:0]        out_length,
  output logic [15:0]       out_time,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data
);

  logic [3:0]        key_offset;
  logic              to_minor;
  logic [1:0]        quirk_mode;

  logic              s1_valid;
  logic [7:0]        s1_status;
  logic [NOTE_W-1:0] s1_note;
  logic [6:0]        s1_vel;
  logic [1:0]        s1_len;
  logic [15:0]       s1_time;
  logic              s1_roll;

  logic              in_fire;
  logic              s1_adv;
  logic              s1_drop;
  logic [7:0]        s1_use;
  logic [7:0]        remapped;
  logic [7:0]        entry;
  store_wr_t         wr;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_offset <= 4'd0;
      to_minor   <= 1'b1;
      quirk_mode <= QUIRK_SKIP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_OFFSET: key_offset <= cfg_data;
        CFG_TO_MINOR:   to_minor   <= cfg_data[0];
        CFG_QUIRK_MODE: quirk_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // working stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status <= status_byte;
      s1_note   <= data_one;
      s1_vel    <= data_two;
      s1_len    <= msg_length;
      s1_time   <= frame_time;
      s1_roll   <= rolling;
    end
  end

  msmr_remap u_remap (
    .note       (s1_note),
    .key_offset (key_offset),
    .to_minor   (to_minor),
    .quirk_mode (quirk_mode),
    .result     (remapped)
  );

  msmr_note_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (data_one),
    .lk_addr (s1_note),
    .wr      (wr),
    .entry   (entry)
  );

  // note message decision and store update
  always_comb begin
    logic is_on;
    logic is_off;
    logic note_on;
    is_on   = (s1_status[7:4] == CMD_NOTE_ON);
    is_off  = (s1_status[7:4] == CMD_NOTE_OFF);
    note_on = is_on && (s1_vel != 7'd0);
    s1_use  = {1'b0, s1_note};
    wr      = '0;
    wr.addr = s1_note;
    wr.data = remapped;
    if (note_on) begin
      if (s1_roll) begin
        s1_use = remapped;
        wr.set = s1_adv;
      end
    end else if ((is_on || is_off) && (entry != MAP_NONE)) begin
      s1_use = entry;
      wr.clr = s1_adv;
    end
    s1_drop = (is_on || is_off) && (s1_use == MAP_DROP);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= !s1_drop;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !s1_drop) begin
      out_status   <= s1_status;
      out_data_one <= s1_use[6:0];
      out_data_two <= s1_vel;
      out_length   <= s1_len;
      out_time     <= s1_time;
    end
  end

  // checks
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input not ready with empty working stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_note) && $stable(s1_status))
    else $error("stalled item changed in working stage");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !s1_drop |=> out_valid)
    else $error("kept item did not reach output register");

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_drop |=> !out_valid)
    else $error("dropped item produced a result");

  a_entry_code: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> entry <= MAP_NONE)
    else $error("stored entry holds an invalid code");

endmodule
